### hdl/lpfa_pkg.sv
package lpfa_pkg;

    localparam int ADDR_BITS = 23;
    localparam int WORD_W = 32;
    localparam int LPF_W = 12;
    localparam int LB_W = 13;
    localparam int FRAME_END_W = LPF_W + LB_W;
    localparam int PAY_W = 24;
    localparam int POS_W = 5;
    localparam int PROD_W = WORD_W + LB_W;
    localparam int CFG_IDX_W = 2;
    localparam int RESULT_DEPTH = 4;
    localparam int RESULT_PTR_W = $clog2(RESULT_DEPTH);
    localparam int RESULT_CNT_W = RESULT_PTR_W + 1;

    localparam logic [POS_W-1:0] HEADER_LEN = POS_W'(18);
    localparam logic [POS_W-1:0] START_END = POS_W'(4);
    localparam logic [POS_W-1:0] COUNT_END = POS_W'(8);
    localparam logic [POS_W-1:0] TAG_OFFSET = POS_W'(14);

    localparam logic [WORD_W-1:0] EXPECTED_TAG_RESET = 32'h1111_1111;
    localparam logic [LPF_W-1:0] LINES_PER_FRAME_RESET = LPF_W'(1440);
    localparam logic [LB_W-1:0] LINE_BYTES_RESET = LB_W'(3240);

    localparam logic [PAY_W-1:0] PAYLOAD_MAX = {PAY_W{1'b1}};

    typedef enum logic [1:0] {
        ST_ACCEPTED = 2'd0,
        ST_WRONG_TAG = 2'd1,
        ST_LINE_OVERFLOW = 2'd2,
        ST_RUNT = 2'd3
    } status_t;

    typedef enum logic {
        KIND_WRITE = 1'b0,
        KIND_STATUS = 1'b1
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_EXPECTED_TAG = 2'd0,
        REG_LINES_PER_FRAME = 2'd1,
        REG_LINE_BYTES = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [WORD_W-1:0] expected_tag;
        logic [LPF_W-1:0] lines_per_frame;
        logic [LB_W-1:0] line_bytes;
        logic [FRAME_END_W-1:0] frame_end;
    } cfg_t;

    typedef struct packed {
        kind_t kind;
        logic [ADDR_BITS-1:0] write_address;
        logic [7:0] write_byte;
        status_t status_code;
        logic address_clipped;
        logic frame_done;
        logic last_result;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t first;
        result_t second;
    } push_t;

endpackage

### hdl/lpfa_intf.sv
interface lpfa_in_if;
    logic valid;
    logic ready;
    logic [7:0] data_byte;
    logic packet_end;

    modport source (output valid, output data_byte, output packet_end, input ready);
    modport sink (input valid, input data_byte, input packet_end, output ready);
endinterface

interface lpfa_out_if;
    import lpfa_pkg::*;

    logic valid;
    logic ready;
    logic kind;
    logic [ADDR_BITS-1:0] write_address;
    logic [7:0] write_byte;
    logic [1:0] status_code;
    logic address_clipped;
    logic frame_done;
    logic last_result;

    modport source (
        output valid, output kind, output write_address, output write_byte,
        output status_code, output address_clipped, output frame_done,
        output last_result, input ready
    );
    modport sink (
        input valid, input kind, input write_address, input write_byte,
        input status_code, input address_clipped, input frame_done,
        input last_result, output ready
    );
endinterface

interface lpfa_cfg_if;
    import lpfa_pkg::*;

    logic valid;
    logic ready;
    logic [CFG_IDX_W-1:0] index;
    logic [WORD_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

### hdl/lpfa_cfg_regs.sv
module lpfa_cfg_regs (
    input  logic            clk,
    input  logic            rst_n,
    lpfa_cfg_if.sink        cfg,
    output lpfa_pkg::cfg_t  regs
);
    import lpfa_pkg::*;

    logic [WORD_W-1:0] tag_reg;
    logic [LPF_W-1:0] lpf_reg;
    logic [LB_W-1:0] lb_reg;
    logic [FRAME_END_W-1:0] frame_end_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg <= EXPECTED_TAG_RESET;
            lpf_reg <= LINES_PER_FRAME_RESET;
            lb_reg <= LINE_BYTES_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (reg_idx_t'(cfg.index))
                REG_EXPECTED_TAG:    tag_reg <= cfg.data;
                REG_LINES_PER_FRAME: lpf_reg <= cfg.data[LPF_W-1:0];
                REG_LINE_BYTES:      lb_reg <= cfg.data[LB_W-1:0];
                default:             ;
            endcase
        end
    end

    // The frame size is registered from the line registers, so it follows them in the next cycle.
    always_ff @(posedge clk)
    begin
        frame_end_reg <= FRAME_END_W'(lpf_reg) * FRAME_END_W'(lb_reg);
    end

    assign regs.expected_tag = tag_reg;
    assign regs.lines_per_frame = lpf_reg;
    assign regs.line_bytes = lb_reg;
    assign regs.frame_end = frame_end_reg;

endmodule

### hdl/lpfa_assembler_core.sv
module lpfa_assembler_core (
    input  logic            clk,
    input  logic            rst_n,
    lpfa_in_if.sink         packet,
    input  lpfa_pkg::cfg_t  regs,
    input  logic            room,
    output lpfa_pkg::push_t push
);
    import lpfa_pkg::*;

    localparam logic [ADDR_BITS:0] ADDR_LIMIT = (ADDR_BITS + 1)'(1) << ADDR_BITS;

    logic in_valid_reg;
    logic [7:0] in_byte_reg;
    logic in_end_reg;
    logic fire;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [WORD_W-1:0] start_reg, start_next;
    logic [WORD_W-1:0] count_reg, count_next;
    logic [WORD_W-1:0] tag_reg, tag_next;
    logic [LPF_W-1:0] lines_reg, lines_next;
    status_t verdict_reg, verdict_next;
    logic [ADDR_BITS:0] next_addr_reg, next_addr_next;
    logic [PAY_W-1:0] left_reg, left_next;
    logic clip_reg, clip_next;

    logic [ADDR_BITS:0] start_prod_reg;
    logic [PAY_W-1:0] pay_prod_reg;
    logic [PROD_W-1:0] start_full;
    logic [PROD_W-1:0] pay_full;

    logic [WORD_W-1:0] tag_full;
    logic [WORD_W:0] judge_sum;
    logic [LPF_W-1:0] lines_sum;
    logic frame_done;
    logic in_range;
    logic wr_valid;
    logic st_valid;
    result_t wr_res;
    result_t st_res;

    assign fire = in_valid_reg && room;
    assign packet.ready = !in_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (packet.ready)
        begin
            in_valid_reg <= packet.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (packet.valid && packet.ready)
        begin
            in_byte_reg <= packet.data_byte;
            in_end_reg <= packet.packet_end;
        end
    end

    // Header products settle long before the last header byte arrives.
    assign start_full = PROD_W'(start_reg) * PROD_W'(regs.line_bytes);
    assign pay_full = PROD_W'(count_reg) * PROD_W'(regs.line_bytes);

    always_ff @(posedge clk)
    begin
        start_prod_reg <= (start_full > PROD_W'(ADDR_LIMIT)) ? ADDR_LIMIT
                                                              : start_full[ADDR_BITS:0];
        pay_prod_reg <= (pay_full > PROD_W'(PAYLOAD_MAX)) ? PAYLOAD_MAX
                                                           : pay_full[PAY_W-1:0];
    end

    assign tag_full = {tag_reg[WORD_W-9:0], in_byte_reg};
    assign judge_sum = (WORD_W + 1)'(lines_reg) + (WORD_W + 1)'(count_reg);
    assign lines_sum = lines_reg + count_reg[LPF_W-1:0];
    assign in_range = (FRAME_END_W'(next_addr_reg) < regs.frame_end) && !next_addr_reg[ADDR_BITS];

    always_comb
    begin
        pos_next = pos_reg;
        start_next = start_reg;
        count_next = count_reg;
        tag_next = tag_reg;
        lines_next = lines_reg;
        verdict_next = verdict_reg;
        next_addr_next = next_addr_reg;
        left_next = left_reg;
        clip_next = clip_reg;
        frame_done = 1'b0;
        wr_valid = 1'b0;
        st_valid = 1'b0;

        if (fire)
        begin
            if (pos_reg < HEADER_LEN)
            begin
                if (pos_reg < START_END)
                begin
                    start_next = {start_reg[WORD_W-9:0], in_byte_reg};
                end
                else if (pos_reg < COUNT_END)
                begin
                    count_next = {count_reg[WORD_W-9:0], in_byte_reg};
                end
                else if (pos_reg >= TAG_OFFSET)
                begin
                    tag_next = tag_full;
                end
                pos_next = pos_reg + POS_W'(1);
                if (pos_reg == HEADER_LEN - POS_W'(1))
                begin
                    if (tag_full != regs.expected_tag)
                    begin
                        verdict_next = ST_WRONG_TAG;
                    end
                    else if (judge_sum > (WORD_W + 1)'(regs.lines_per_frame))
                    begin
                        verdict_next = ST_LINE_OVERFLOW;
                    end
                    else
                    begin
                        verdict_next = ST_ACCEPTED;
                        left_next = pay_prod_reg;
                        next_addr_next = start_prod_reg;
                    end
                end
            end
            else if (verdict_reg == ST_ACCEPTED && left_reg != '0)
            begin
                if (in_range)
                begin
                    wr_valid = 1'b1;
                end
                else
                begin
                    clip_next = 1'b1;
                end
                left_next = left_reg - PAY_W'(1);
                if (!next_addr_reg[ADDR_BITS])
                begin
                    next_addr_next = next_addr_reg + (ADDR_BITS + 1)'(1);
                end
            end

            if (in_end_reg)
            begin
                st_valid = 1'b1;
                if (pos_next >= HEADER_LEN && verdict_next == ST_ACCEPTED)
                begin
                    frame_done = (lines_sum == regs.lines_per_frame);
                    lines_next = frame_done ? '0 : lines_sum;
                end
                pos_next = '0;
                start_next = '0;
                count_next = '0;
                tag_next = '0;
                verdict_next = ST_ACCEPTED;
                next_addr_next = '0;
                left_next = '0;
            end
        end
    end

    always_comb
    begin
        wr_res.kind = KIND_WRITE;
        wr_res.write_address = next_addr_reg[ADDR_BITS-1:0];
        wr_res.write_byte = in_byte_reg;
        wr_res.status_code = ST_ACCEPTED;
        wr_res.address_clipped = 1'b0;
        wr_res.frame_done = 1'b0;
        wr_res.last_result = !in_end_reg;

        st_res.kind = KIND_STATUS;
        st_res.write_address = '0;
        st_res.write_byte = '0;
        st_res.status_code = (pos_reg < HEADER_LEN && pos_reg != HEADER_LEN - POS_W'(1))
                             ? ST_RUNT
                             : ((pos_reg < HEADER_LEN) ? verdict_next_hdr() : verdict_reg);
        st_res.address_clipped = clip_next;
        st_res.frame_done = frame_done;
        st_res.last_result = 1'b1;

        push.count = {1'b0, wr_valid} + {1'b0, st_valid};
        push.first = wr_valid ? wr_res : st_res;
        push.second = st_res;
    end

    // Verdict of a header whose last byte is in the input register.
    function automatic status_t verdict_next_hdr();
        status_t v;
        if (tag_full != regs.expected_tag)
        begin
            v = ST_WRONG_TAG;
        end
        else if (judge_sum > (WORD_W + 1)'(regs.lines_per_frame))
        begin
            v = ST_LINE_OVERFLOW;
        end
        else
        begin
            v = ST_ACCEPTED;
        end
        return v;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            start_reg <= '0;
            count_reg <= '0;
            tag_reg <= '0;
            lines_reg <= '0;
            verdict_reg <= ST_ACCEPTED;
            next_addr_reg <= '0;
            left_reg <= '0;
            clip_reg <= 1'b0;
        end
        else
        begin
            pos_reg <= pos_next;
            start_reg <= start_next;
            count_reg <= count_next;
            tag_reg <= tag_next;
            lines_reg <= lines_next;
            verdict_reg <= verdict_next;
            next_addr_reg <= next_addr_next;
            left_reg <= left_next;
            clip_reg <= (fire && in_end_reg) ? 1'b0 : clip_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) pos_reg <= HEADER_LEN)
        else $error("Header position ran past the header length.");

    assert property (@(posedge clk) disable iff (!rst_n)
        left_reg != '0 |-> (pos_reg == HEADER_LEN && verdict_reg == ST_ACCEPTED))
        else $error("Payload pending outside an accepted packet.");

    assert property (@(posedge clk) disable iff (!rst_n)
        fire && in_end_reg |=> (pos_reg == '0 && left_reg == '0 && !clip_reg))
        else $error("Packet state not cleared after the last byte.");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !room |=> in_valid_reg)
        else $error("Held request dropped while the result queue was full.");

endmodule

### hdl/lpfa_result_fifo.sv
module lpfa_result_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  lpfa_pkg::push_t push,
    output logic            room,
    lpfa_out_if.source      result
);
    import lpfa_pkg::*;

    result_t mem [RESULT_DEPTH];
    logic [RESULT_PTR_W-1:0] wr_ptr_reg;
    logic [RESULT_PTR_W-1:0] rd_ptr_reg;
    logic [RESULT_CNT_W-1:0] cnt_reg;
    logic pop;
    result_t head;

    assign room = cnt_reg <= RESULT_CNT_W'(RESULT_DEPTH - 2);
    assign pop = result.valid && result.ready;
    assign head = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            mem[wr_ptr_reg + RESULT_PTR_W'(1)] <= push.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + RESULT_PTR_W'(push.count);
            rd_ptr_reg <= rd_ptr_reg + RESULT_PTR_W'(pop);
            cnt_reg <= cnt_reg + RESULT_CNT_W'(push.count) - RESULT_CNT_W'(pop);
        end
    end

    assign result.valid = cnt_reg != '0;
    assign result.kind = head.kind;
    assign result.write_address = head.write_address;
    assign result.write_byte = head.write_byte;
    assign result.status_code = head.status_code;
    assign result.address_clipped = head.address_clipped;
    assign result.frame_done = head.frame_done;
    assign result.last_result = head.last_result;

    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= RESULT_CNT_W'(RESULT_DEPTH))
        else $error("Result queue overfilled.");

endmodule

### hdl/line_packet_frame_assembler_top.sv
// Line packet frame assembler.
// The packet channel takes one packet byte per request, with packet_end set on
// the last byte. The first 18 bytes are the header; later bytes are payload.
// The result channel returns frame memory writes (kind 0) and one status per
// packet (kind 1, on its last byte); last_result marks the final result of a byte.
// The cfg channel writes expected_tag (index 0), lines_per_frame (index 1) and
// line_bytes (index 2); it is always ready. The user writes it only while idle; the block does not enforce this.
// A byte is taken into an input register and decoded once the queue has room for
// two results; its results are then written into a four-entry result queue, from
// which the first result of a byte is offered to the receiver.
// One byte is accepted every cycle while the queue has room for two results.
// The last byte of a packet may yield a write and a status together; these
// leave the queue one per cycle while the receiver is ready.
// When the receiver stalls, the queue fills and the packet channel drops ready
// until room returns; no result is lost or repeated.
// Reset clears the header state, the line total and the queue, and loads the
// registers with tag 0x11111111, 1440 lines per frame and 3240 bytes per line.
module line_packet_frame_assembler_top (
    input  logic        clk,
    input  logic        rst_n,
    lpfa_in_if.sink     packet,
    lpfa_cfg_if.sink    cfg,
    lpfa_out_if.source  result
);
    import lpfa_pkg::*;

    cfg_t regs;
    push_t push;
    logic room;

    lpfa_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    lpfa_assembler_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .packet (packet),
        .regs   (regs),
        .room   (room),
        .push   (push)
    );

    lpfa_result_fifo u_result_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .room   (room),
        .result (result)
    );

endmodule
